// ===== hdl/chip8_pkg.sv =====
`default_nettype none
package chip8_pkg;

  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned FRAME_W     = 64;
  localparam int unsigned FRAME_H     = 32;
  localparam int unsigned STACK_DEPTH = 16;
  localparam logic [ADDR_W-1:0] START_PC = 12'h200;

  // Item codes on the input channel
  typedef enum logic [1:0] {
    ITEM_WRITE = 2'd0,
    ITEM_EXEC  = 2'd1,
    ITEM_ROW   = 2'd2,
    ITEM_NONE  = 2'd3
  } item_op_e;

  // Instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SE_NN = 4'h3;
  localparam logic [3:0] GRP_SNE_NN = 4'h4;
  localparam logic [3:0] GRP_SE_V  = 4'h5;
  localparam logic [3:0] GRP_LD_NN = 4'h6;
  localparam logic [3:0] GRP_ADD_NN = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNE_V = 4'h9;
  localparam logic [3:0] GRP_LD_I  = 4'hA;
  localparam logic [3:0] GRP_JP_V0 = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;
  localparam logic [3:0] GRP_DRW   = 4'hD;
  localparam logic [3:0] GRP_KEY   = 4'hE;
  localparam logic [3:0] GRP_MISC  = 4'hF;

  // System low bytes
  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  // 8xy sub-codes
  localparam logic [3:0] SUB_MOV  = 4'h0;
  localparam logic [3:0] SUB_OR   = 4'h1;
  localparam logic [3:0] SUB_AND  = 4'h2;
  localparam logic [3:0] SUB_XOR  = 4'h3;
  localparam logic [3:0] SUB_ADD  = 4'h4;
  localparam logic [3:0] SUB_SUB  = 4'h5;
  localparam logic [3:0] SUB_SHR  = 4'h6;
  localparam logic [3:0] SUB_RSUB = 4'h7;
  localparam logic [3:0] SUB_SHL  = 4'hE;

  // Fx low bytes
  localparam logic [7:0] FX_GET_DT = 8'h07;
  localparam logic [7:0] FX_SET_DT = 8'h15;
  localparam logic [7:0] FX_FONT   = 8'h29;
  localparam logic [7:0] FX_BCD    = 8'h33;
  localparam logic [7:0] FX_LOAD   = 8'h65;

  typedef enum logic [3:0] {
    ALU_MOV,
    ALU_OR,
    ALU_AND,
    ALU_XOR,
    ALU_ADD,
    ALU_SUB,
    ALU_SHR,
    ALU_RSUB,
    ALU_SHL
  } alu_op_e;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_INSTR,
    ST_READ_X,
    ST_READ_Y,
    ST_EXEC,
    ST_WRITE_X,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_DRAW_END,
    ST_BCD,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_FIN
  } state_e;

  // Hundreds, tens and ones of a byte, one nibble each
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [1:0] h;
    logic [6:0] r;
    logic [3:0] t;
    logic [6:0] o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h) * 8'd100);
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 7'(i * 10)) t = 4'(i);
    end
    o = 7'(r - 7'(t) * 7'd10);
    return {2'b00, h, t, o[3:0]};
  endfunction

  // Sprite byte placed at column sh, wrapping across the row
  function automatic logic [FRAME_W-1:0] sprite_mask(input logic [7:0] b,
                                                     input logic [5:0] sh);
    logic [FRAME_W-1:0]   w;
    logic [2*FRAME_W-1:0] ww;
    w  = {b, {(FRAME_W-8){1'b0}}};
    ww = {w, w} >> sh;
    return ww[FRAME_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/chip8_ram.sv =====
`default_nettype none
module chip8_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = chip8_pkg::MEM_BYTES
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/chip8_alu.sv =====
`default_nettype none
module chip8_alu (
  input  wire logic [7:0]         a_i,
  input  wire logic [7:0]         b_i,
  input  wire chip8_pkg::alu_op_e op_i,
  output chip8_pkg::alu_res_t     res_o
);

  logic [8:0] sum;

  always_comb begin
    sum        = {1'b0, a_i} + {1'b0, b_i};
    res_o.eq   = (a_i == b_i);
    res_o.res  = b_i;
    res_o.flag = 1'b0;
    case (op_i)
      chip8_pkg::ALU_MOV: res_o.res = b_i;
      chip8_pkg::ALU_OR:  res_o.res = a_i | b_i;
      chip8_pkg::ALU_AND: res_o.res = a_i & b_i;
      chip8_pkg::ALU_XOR: res_o.res = a_i ^ b_i;
      chip8_pkg::ALU_ADD: begin
        res_o.res  = sum[7:0];
        res_o.flag = sum[8];
      end
      chip8_pkg::ALU_SUB: begin
        res_o.res  = a_i - b_i;
        res_o.flag = (a_i >= b_i);
      end
      chip8_pkg::ALU_RSUB: begin
        res_o.res  = b_i - a_i;
        res_o.flag = (b_i >= a_i);
      end
      chip8_pkg::ALU_SHR: begin
        res_o.res  = {1'b0, a_i[7:1]};
        res_o.flag = a_i[0];
      end
      chip8_pkg::ALU_SHL: begin
        res_o.res  = {a_i[6:0], 1'b0};
        res_o.flag = a_i[7];
      end
      default: res_o.res = b_i;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/chip8_instruction_executor.sv =====
// Memory write, row read and unused items go to the finish state; an instruction fetches
//   two bytes, reads Vx and Vy and executes, plus a Vx write for flag-setting 8xy ops, a
//   read and write per sprite row and a VF write on DXYN, digit writes for Fx33 and a read
//   and write per Fx65 register, from the registered memory read and single write port.
// Throughput: one item at a time; the next word is taken once the sequencer is idle.
// Reset: asynchronous, active low; registers, I, stack pointer, timer and frame clear,
//   PC loads 0x200. Byte memory and call stack hold no reset value.
`default_nettype none
module chip8_instruction_executor #(
  parameter int unsigned StackDepth = chip8_pkg::STACK_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [7:0]  random_byte_i,
  input  wire logic [4:0]  row_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      pc_out_o,
  output logic             status_o,
  output logic [63:0]      row_pixels_o
);

  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned AW  = chip8_pkg::ADDR_W;
  localparam int unsigned FW  = chip8_pkg::FRAME_W;
  localparam int unsigned FH  = chip8_pkg::FRAME_H;

  chip8_pkg::state_e state_q, state_d;

  logic [AW-1:0]  pc_q, pc_d, idx_q, idx_d, nxt_q, nxt_d;
  logic [SpW-1:0] sp_q, sp_d, sp_inc, sp_dec;
  logic [7:0]     delay_q, delay_d;
  logic [7:0]     regs_q [16];
  logic [AW-1:0]  stack_q [StackDepth];
  logic [FW-1:0]  frame_q [FH];

  logic [15:0] instr_q, instr_d;
  logic [7:0]  hi_q, hi_d, vx_q, vx_d, vy_q, vy_d, rnd_q, rnd_d, res_q, res_d;
  logic [1:0]  kind_q, kind_d;
  logic [4:0]  row_q, row_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        unk_q, unk_d, coll_q, coll_d;

  logic          out_valid_q, out_valid_d, status_q, status_d;
  logic [AW-1:0] pc_out_q, pc_out_d;
  logic [FW-1:0] pix_q, pix_d;

  // Memory port
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra, addr_sum;
  logic [7:0]    mem_wd, rd_data;

  // Register file, frame and stack write controls
  logic       reg_we;
  logic [3:0] reg_wa, reg_ra;
  logic [7:0] reg_wd, reg_rd;
  logic       stk_we, frm_we, frm_clr;
  logic [4:0] yy, frm_idx;
  logic [FW-1:0] frame_row, mask;

  // Shared ALU
  chip8_pkg::alu_op_e  alu_op;
  logic [7:0]          alu_b;
  chip8_pkg::alu_res_t alu_res;

  logic [3:0]  grp, x, y, n;
  logic [7:0]  nn;
  logic [11:0] bcd;

  assign grp = instr_q[15:12];
  assign x   = instr_q[11:8];
  assign y   = instr_q[7:4];
  assign n   = instr_q[3:0];
  assign nn  = instr_q[7:0];

  assign sp_inc = (sp_q == SpW'(StackDepth - 1)) ? '0 : SpW'(sp_q + 1'b1);
  assign sp_dec = (sp_q == '0) ? SpW'(StackDepth - 1) : SpW'(sp_q - 1'b1);

  // I plus the step counter: sprite rows, BCD digits and register loads
  assign addr_sum = AW'(idx_q + {{(AW-4){1'b0}}, cnt_q});

  // Sprite row wraps at the frame height; column from Vx modulo the width
  assign yy        = 5'(vy_q[4:0] + {1'b0, cnt_q});
  assign mask      = chip8_pkg::sprite_mask(rd_data, vx_q[5:0]);
  assign frm_idx   = (state_q == chip8_pkg::ST_FIN) ? row_q : yy;
  assign frame_row = frame_q[frm_idx];

  assign reg_ra = (state_q == chip8_pkg::ST_READ_Y) ? y : x;
  assign reg_rd = regs_q[reg_ra];
  assign bcd    = chip8_pkg::bcd_digits(vx_q);

  chip8_ram #(
    .Width (8),
    .Depth (chip8_pkg::MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (rd_data)
  );

  chip8_alu u_alu (
    .a_i   (vx_q),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  assign in_ready_o   = (state_q == chip8_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign pc_out_o     = pc_out_q;
  assign status_o     = status_q;
  assign row_pixels_o = pix_q;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    idx_d   = idx_q;
    nxt_d   = nxt_q;
    sp_d    = sp_q;
    delay_d = delay_q;
    instr_d = instr_q;
    hi_d    = hi_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    rnd_d   = rnd_q;
    res_d   = res_q;
    kind_d  = kind_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    unk_d   = unk_q;
    coll_d  = coll_q;

    // Drop the result word once taken
    out_valid_d = out_valid_q & ~out_ready_i;
    pc_out_d    = pc_out_q;
    status_d    = status_q;
    pix_d       = pix_q;

    mem_we  = 1'b0;
    mem_wa  = address_i;
    mem_wd  = data_i;
    mem_ra  = pc_q;
    reg_we  = 1'b0;
    reg_wa  = x;
    reg_wd  = alu_res.res;
    stk_we  = 1'b0;
    frm_we  = 1'b0;
    frm_clr = 1'b0;
    alu_op  = chip8_pkg::ALU_MOV;
    alu_b   = vy_q;

    case (state_q)
      chip8_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = opcode_i;
          row_d  = row_i;
          rnd_d  = random_byte_i;
          unk_d  = 1'b0;
          case (opcode_i)
            chip8_pkg::ITEM_WRITE: begin
              mem_we  = 1'b1;
              state_d = chip8_pkg::ST_FIN;
            end
            chip8_pkg::ITEM_EXEC: state_d = chip8_pkg::ST_FETCH_HI;
            default:              state_d = chip8_pkg::ST_FIN;
          endcase
        end
      end

      // Fetch the two instruction bytes through the registered read port
      chip8_pkg::ST_FETCH_HI: begin
        mem_ra  = pc_q;
        state_d = chip8_pkg::ST_FETCH_LO;
      end
      chip8_pkg::ST_FETCH_LO: begin
        mem_ra  = AW'(pc_q + 1'b1);
        hi_d    = rd_data;
        state_d = chip8_pkg::ST_INSTR;
      end
      chip8_pkg::ST_INSTR: begin
        instr_d = {hi_q, rd_data};
        state_d = chip8_pkg::ST_READ_X;
      end
      chip8_pkg::ST_READ_X: begin
        vx_d    = reg_rd;
        state_d = chip8_pkg::ST_READ_Y;
      end
      chip8_pkg::ST_READ_Y: begin
        vy_d    = reg_rd;
        nxt_d   = AW'(pc_q + 2'd2);
        state_d = chip8_pkg::ST_EXEC;
      end

      chip8_pkg::ST_EXEC: begin
        state_d = chip8_pkg::ST_FIN;
        case (grp)
          chip8_pkg::GRP_SYS: begin
            if (nn == chip8_pkg::SYS_CLS) begin
              frm_clr = 1'b1;
            end else if (nn == chip8_pkg::SYS_RET) begin
              sp_d  = sp_dec;
              nxt_d = AW'(stack_q[sp_dec] + 2'd2);
            end else begin
              unk_d = 1'b1;
            end
          end
          chip8_pkg::GRP_JP: nxt_d = instr_q[11:0];
          chip8_pkg::GRP_CALL: begin
            stk_we = 1'b1;
            sp_d   = sp_inc;
            nxt_d  = instr_q[11:0];
          end
          chip8_pkg::GRP_SE_NN: begin
            alu_b = nn;
            if (alu_res.eq) nxt_d = AW'(nxt_q + 2'd2);
          end
          chip8_pkg::GRP_SNE_NN: begin
            alu_b = nn;
            if (!alu_res.eq) nxt_d = AW'(nxt_q + 2'd2);
          end
          chip8_pkg::GRP_SE_V: begin
            if (alu_res.eq) nxt_d = AW'(nxt_q + 2'd2);
          end
          chip8_pkg::GRP_SNE_V: begin
            if (!alu_res.eq) nxt_d = AW'(nxt_q + 2'd2);
          end
          chip8_pkg::GRP_LD_NN: begin
            reg_we = 1'b1;
            reg_wd = nn;
          end
          chip8_pkg::GRP_ADD_NN: begin
            alu_op = chip8_pkg::ALU_ADD;
            alu_b  = nn;
            reg_we = 1'b1;
          end
          chip8_pkg::GRP_ALU: begin
            case (n)
              chip8_pkg::SUB_MOV: begin
                alu_op = chip8_pkg::ALU_MOV;
                reg_we = 1'b1;
              end
              chip8_pkg::SUB_OR: begin
                alu_op = chip8_pkg::ALU_OR;
                reg_we = 1'b1;
              end
              chip8_pkg::SUB_AND: begin
                alu_op = chip8_pkg::ALU_AND;
                reg_we = 1'b1;
              end
              chip8_pkg::SUB_XOR: begin
                alu_op = chip8_pkg::ALU_XOR;
                reg_we = 1'b1;
              end
              chip8_pkg::SUB_ADD, chip8_pkg::SUB_SUB, chip8_pkg::SUB_SHR,
              chip8_pkg::SUB_RSUB, chip8_pkg::SUB_SHL: begin
                case (n)
                  chip8_pkg::SUB_ADD:  alu_op = chip8_pkg::ALU_ADD;
                  chip8_pkg::SUB_SUB:  alu_op = chip8_pkg::ALU_SUB;
                  chip8_pkg::SUB_SHR:  alu_op = chip8_pkg::ALU_SHR;
                  chip8_pkg::SUB_RSUB: alu_op = chip8_pkg::ALU_RSUB;
                  default:             alu_op = chip8_pkg::ALU_SHL;
                endcase
                // Flag goes to VF first; Vx follows, so Vx wins when x is F
                reg_we  = 1'b1;
                reg_wa  = 4'hF;
                reg_wd  = {7'd0, alu_res.flag};
                res_d   = alu_res.res;
                state_d = chip8_pkg::ST_WRITE_X;
              end
              default: unk_d = 1'b1;
            endcase
          end
          chip8_pkg::GRP_LD_I:  idx_d = instr_q[11:0];
          chip8_pkg::GRP_JP_V0: nxt_d = AW'(instr_q[11:0] + {4'd0, regs_q[0]});
          chip8_pkg::GRP_RND: begin
            reg_we = 1'b1;
            reg_wd = rnd_q & nn;
          end
          chip8_pkg::GRP_DRW: begin
            coll_d  = 1'b0;
            cnt_d   = 4'd0;
            state_d = (n == 4'd0) ? chip8_pkg::ST_DRAW_END : chip8_pkg::ST_DRAW_RD;
          end
          chip8_pkg::GRP_KEY: ;
          default: begin
            case (nn)
              chip8_pkg::FX_GET_DT: begin
                reg_we = 1'b1;
                reg_wd = delay_q;
              end
              chip8_pkg::FX_SET_DT: delay_d = vx_q;
              chip8_pkg::FX_FONT:   idx_d = AW'({2'b00, vx_q, 2'b00} + {4'd0, vx_q});
              chip8_pkg::FX_BCD: begin
                cnt_d   = 4'd0;
                state_d = chip8_pkg::ST_BCD;
              end
              chip8_pkg::FX_LOAD: begin
                cnt_d   = 4'd0;
                state_d = chip8_pkg::ST_LOAD_RD;
              end
              default: unk_d = 1'b1;
            endcase
          end
        endcase
      end

      chip8_pkg::ST_WRITE_X: begin
        reg_we  = 1'b1;
        reg_wd  = res_q;
        state_d = chip8_pkg::ST_FIN;
      end

      // Sprite: read one byte, then XOR it into its wrapped row
      chip8_pkg::ST_DRAW_RD: begin
        mem_ra  = addr_sum;
        state_d = chip8_pkg::ST_DRAW_WR;
      end
      chip8_pkg::ST_DRAW_WR: begin
        frm_we = 1'b1;
        coll_d = coll_q | (|(frame_row & mask));
        if (cnt_q == 4'(n - 1'b1)) begin
          state_d = chip8_pkg::ST_DRAW_END;
        end else begin
          cnt_d   = 4'(cnt_q + 1'b1);
          state_d = chip8_pkg::ST_DRAW_RD;
        end
      end
      chip8_pkg::ST_DRAW_END: begin
        reg_we  = 1'b1;
        reg_wa  = 4'hF;
        reg_wd  = {7'd0, coll_q};
        state_d = chip8_pkg::ST_FIN;
      end

      // Hundreds, tens, ones to I, I+1, I+2
      chip8_pkg::ST_BCD: begin
        mem_we = 1'b1;
        mem_wa = addr_sum;
        case (cnt_q[1:0])
          2'd0:    mem_wd = {4'd0, bcd[11:8]};
          2'd1:    mem_wd = {4'd0, bcd[7:4]};
          default: mem_wd = {4'd0, bcd[3:0]};
        endcase
        if (cnt_q == 4'd2) begin
          state_d = chip8_pkg::ST_FIN;
        end else begin
          cnt_d = 4'(cnt_q + 1'b1);
        end
      end

      chip8_pkg::ST_LOAD_RD: begin
        mem_ra  = addr_sum;
        state_d = chip8_pkg::ST_LOAD_WR;
      end
      chip8_pkg::ST_LOAD_WR: begin
        reg_we = 1'b1;
        reg_wa = cnt_q;
        reg_wd = rd_data;
        if (cnt_q == x) begin
          state_d = chip8_pkg::ST_FIN;
        end else begin
          cnt_d   = 4'(cnt_q + 1'b1);
          state_d = chip8_pkg::ST_LOAD_RD;
        end
      end

      // Hold until the output register is free, then for an instruction commit PC and step the timer
      chip8_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (kind_q == chip8_pkg::ITEM_EXEC) begin
            pc_d     = nxt_q;
            pc_out_d = nxt_q;
            status_d = unk_q;
            delay_d  = (delay_q == 8'd0) ? 8'd0 : 8'(delay_q - 1'b1);
          end else begin
            pc_out_d = pc_q;
            status_d = 1'b0;
          end
          pix_d   = (kind_q == chip8_pkg::ITEM_ROW) ? frame_row : '0;
          state_d = chip8_pkg::ST_IDLE;
        end
      end

      default: state_d = chip8_pkg::ST_IDLE;
    endcase

    // Start address write loads PC at once
    if (cfg_we_i) begin
      pc_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chip8_pkg::ST_IDLE;
      pc_q        <= chip8_pkg::START_PC;
      idx_q       <= '0;
      sp_q        <= '0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) regs_q[i] <= '0;
      for (int i = 0; i < FH; i++) frame_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      sp_q        <= sp_d;
      delay_q     <= delay_d;
      out_valid_q <= out_valid_d;
      if (reg_we) regs_q[reg_wa] <= reg_wd;
      if (frm_clr) begin
        for (int i = 0; i < FH; i++) frame_q[i] <= '0;
      end else if (frm_we) begin
        frame_q[yy] <= frame_row ^ mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q    <= nxt_d;
    instr_q  <= instr_d;
    hi_q     <= hi_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    rnd_q    <= rnd_d;
    res_q    <= res_d;
    kind_q   <= kind_d;
    row_q    <= row_d;
    cnt_q    <= cnt_d;
    unk_q    <= unk_d;
    coll_q   <= coll_d;
    pc_out_q <= pc_out_d;
    status_q <= status_d;
    pix_q    <= pix_d;
    if (stk_we) stack_q[sp_q] <= pc_q;
  end

endmodule
`default_nettype wire
